// ===== rtl/core/e1d_pkg.sv =====
// ----------------------------------------------------------------------------
// e1d_pkg
// shared types, widths and codes of the 1-d subpixel edge detector
// ----------------------------------------------------------------------------
package e1d_pkg;

    localparam int MAX_PROFILE_LENGTH = 4096;
    localparam int CNT_W              = $clog2(MAX_PROFILE_LENGTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int GRAD_W   = 18;
    localparam int AMP_W    = 17;
    localparam int POS_W    = 20;
    localparam int FRAC_W   = 8;
    localparam int OFF_W    = 9;
    localparam int QBITS    = 9;
    localparam int QCNT_W   = $clog2(QBITS + 1);
    localparam int DHALF_W  = 18;
    localparam int DEN_W    = 19;
    localparam int REM_W    = 20;
    localparam int POL_W    = 2;

    // half a sample with 8 fraction bits
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(128);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY_MODE = CFG_IDX_W'(1);

    localparam logic [POL_W-1:0] POL_ANY  = 2'd0;
    localparam logic [POL_W-1:0] POL_RISE = 2'd1;
    localparam logic [POL_W-1:0] POL_FALL = 2'd2;

    typedef enum logic [1:0] {
        WIN_HOLD   = 2'd0,
        WIN_SAMPLE = 2'd1,
        WIN_END    = 2'd2,
        WIN_CLEAR  = 2'd3
    } win_op_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] g0;
        logic signed [GRAD_W-1:0] g1;
        logic signed [GRAD_W-1:0] g2;
        logic [CNT_W-1:0]         count;
    } win_t;

    typedef struct packed {
        logic             edge_valid;
        logic [POS_W-1:0] position;
        logic [AMP_W-1:0] amplitude;
        logic             rising;
        logic             end_of_profile;
    } result_t;

    function automatic logic [AMP_W-1:0] grad_mag(input logic signed [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] n;
        n = -g;
        return g[GRAD_W-1] ? n[AMP_W-1:0] : g[AMP_W-1:0];
    endfunction

endpackage

// ===== rtl/core/edge_1d_subpixel_detector_core.sv =====
// ----------------------------------------------------------------------------
// edge_1d_subpixel_detector_core
// 1-d gradient edge detector with parabolic subpixel refinement
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one profile sample per item, tlast on the final sample
//   m_ channel: one item per edge (tuser = 1) or a bare end marker (tuser = 0);
//     tlast marks the last item caused by the final sample of a profile
//   cfg channel: always ready; index 0 min_amplitude, 1 polarity_mode,
//     other indexes ignored; write only while the block is idle
// timing:
//   an item without a peak check (first three samples) takes 1 cycle
//   an item with a peak check takes 2 cycles, plus 11 when it yields an edge
//     (9 steps of the one-bit-per-cycle offset divider, its hand-off, the emit)
//   a final sample runs up to two checks, so up to 26 cycles
//   the offset divider sets the rate; s_tready is high only in the idle state
// reset: aresetn low clears windows, count, registers and the output item
// stall: results sit in a one-item output register; a new sample is taken
//   while the last result still waits, and the next result waits for it
// ----------------------------------------------------------------------------
module edge_1d_subpixel_detector_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [e1d_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    input  logic                              s_tlast,   // last_sample
    // edge results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [e1d_pkg::M_TDATA_W-1:0]     m_tdata,   // [19:0] position,
                                                         // [36:20] amplitude,
                                                         // [37] rising, zero above
    output logic                              m_tuser,   // edge_valid
    output logic                              m_tlast,   // end_of_profile
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [e1d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [e1d_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CHK1 = 7'b0000010,
        ST_DIV1 = 7'b0000100,
        ST_FIN  = 7'b0001000,
        ST_CHK2 = 7'b0010000,
        ST_DIV2 = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [e1d_pkg::AMP_W-1:0]       min_amp_reg, min_amp_next;
    logic [e1d_pkg::POL_W-1:0]       pol_reg, pol_next;
    logic                            last_reg, last_next;
    logic [e1d_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [e1d_pkg::AMP_W-1:0]       amp_reg, amp_next;
    logic                            rise_reg, rise_next;
    e1d_pkg::result_t                pend_reg, pend_next;
    logic                            pend_vld_reg, pend_vld_next;
    e1d_pkg::result_t                e2_reg, e2_next;
    logic                            e2_vld_reg, e2_vld_next;
    e1d_pkg::result_t                out_reg, out_next;
    logic                            out_vld_reg, out_vld_next;

    e1d_pkg::win_op_t                win_op;
    e1d_pkg::win_t                   win;
    logic                            div_start;
    logic                            div_done;
    logic signed [e1d_pkg::OFF_W-1:0] div_off;

    logic [e1d_pkg::AMP_W-1:0]       mag_a, mag_b, mag_c;
    logic                            g_rise;
    logic                            pol_ok;
    logic                            hit;
    logic                            s_acc;
    logic                            full;
    logic                            out_free;
    logic [e1d_pkg::POS_W-1:0]       pos_base;
    logic [e1d_pkg::POS_W-1:0]       off_ext;
    e1d_pkg::result_t                edge_res;
    e1d_pkg::result_t                marker;

    e1d_win u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (win_op),
        .sample  (s_tdata[e1d_pkg::SAMPLE_W-1:0]),
        .win     (win)
    );

    // shared offset divider, used for both peak checks of an item
    e1d_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (mag_a),
        .b       (mag_b),
        .c       (mag_c),
        .done    (div_done),
        .offset  (div_off)
    );

    // peak test on the middle gradient of the window
    always_comb begin
        mag_a  = e1d_pkg::grad_mag(win.g0);
        mag_b  = e1d_pkg::grad_mag(win.g1);
        mag_c  = e1d_pkg::grad_mag(win.g2);
        g_rise = (win.g1 > 0);
        unique case (pol_reg)
            e1d_pkg::POL_RISE: pol_ok = g_rise;
            e1d_pkg::POL_FALL: pol_ok = !g_rise;
            default:           pol_ok = 1'b1;   // any edge, unused code too
        endcase
        hit = (mag_b >= min_amp_reg) && (mag_b >= mag_a) && (mag_b > mag_c) && pol_ok;
    end

    // edge item from the captured peak and the divider offset
    always_comb begin
        pos_base = e1d_pkg::POS_W'({idx_reg, {e1d_pkg::FRAC_W{1'b0}}});
        off_ext  = {{(e1d_pkg::POS_W - e1d_pkg::OFF_W){div_off[e1d_pkg::OFF_W-1]}}, div_off};
        edge_res.edge_valid     = 1'b1;
        edge_res.position       = pos_base + off_ext;
        edge_res.amplitude      = amp_reg;
        edge_res.rising         = rise_reg;
        edge_res.end_of_profile = 1'b0;
        marker                  = '0;
        marker.end_of_profile   = 1'b1;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (win.count >= e1d_pkg::CNT_W'(e1d_pkg::MAX_PROFILE_LENGTH));
    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        min_amp_next  = min_amp_reg;
        pol_next      = pol_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        amp_next      = amp_reg;
        rise_next     = rise_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        e2_next       = e2_reg;
        e2_vld_next   = e2_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        win_op        = e1d_pkg::WIN_HOLD;
        div_start     = 1'b0;

        // register writes
        if (cfg_valid) begin
            if (cfg_index == e1d_pkg::CFG_MIN_AMPLITUDE) begin
                min_amp_next = cfg_data[e1d_pkg::AMP_W-1:0];
            end else if (cfg_index == e1d_pkg::CFG_POLARITY_MODE) begin
                pol_next = cfg_data[e1d_pkg::POL_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    last_next = s_tlast;
                    if (!full) begin
                        win_op = e1d_pkg::WIN_SAMPLE;
                    end
                    // peak check needs three samples before this one
                    if (!full && win.count >= e1d_pkg::CNT_W'(3)) begin
                        state_next = ST_CHK1;
                    end else if (s_tlast) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_CHK1: begin
                if (hit) begin
                    div_start  = 1'b1;
                    idx_next   = win.count - e1d_pkg::CNT_W'(3);
                    amp_next   = mag_b;
                    rise_next  = g_rise;
                    state_next = ST_DIV1;
                end else begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    pend_next     = edge_res;
                    pend_vld_next = 1'b1;
                    state_next    = last_reg ? ST_FIN : ST_EMIT;
                end
            end
            ST_FIN: begin
                if (win.count >= e1d_pkg::CNT_W'(3)) begin
                    win_op     = e1d_pkg::WIN_END;
                    state_next = ST_CHK2;
                end else begin
                    // short profile: nothing to check
                    win_op = e1d_pkg::WIN_CLEAR;
                    if (!pend_vld_reg) begin
                        e2_next     = marker;
                        e2_vld_next = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_CHK2: begin
                if (hit) begin
                    div_start  = 1'b1;
                    idx_next   = win.count - e1d_pkg::CNT_W'(2);
                    amp_next   = mag_b;
                    rise_next  = g_rise;
                    state_next = ST_DIV2;
                end else begin
                    win_op = e1d_pkg::WIN_CLEAR;
                    if (!pend_vld_reg) begin
                        e2_next     = marker;
                        e2_vld_next = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    e2_next                = edge_res;
                    e2_next.end_of_profile = 1'b1;
                    e2_vld_next            = 1'b1;
                    win_op                 = e1d_pkg::WIN_CLEAR;
                    state_next             = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (pend_vld_reg) begin
                        out_next                = pend_reg;
                        out_next.end_of_profile = last_reg && !e2_vld_reg;
                        out_vld_next            = 1'b1;
                        pend_vld_next           = 1'b0;
                        state_next              = e2_vld_reg ? ST_EMIT : ST_IDLE;
                    end else if (e2_vld_reg) begin
                        out_next     = e2_reg;
                        out_vld_next = 1'b1;
                        e2_vld_next  = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            min_amp_reg  <= '0;
            pol_reg      <= e1d_pkg::POL_ANY;
            last_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            e2_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            min_amp_reg  <= min_amp_next;
            pol_reg      <= pol_next;
            last_reg     <= last_next;
            pend_vld_reg <= pend_vld_next;
            e2_vld_reg   <= e2_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        amp_reg  <= amp_next;
        rise_reg <= rise_next;
        pend_reg <= pend_next;
        e2_reg   <= e2_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = out_reg.edge_valid;
    assign m_tlast   = out_reg.end_of_profile;
    assign m_tdata   = e1d_pkg::M_TDATA_W'({out_reg.rising, out_reg.amplitude,
                                            out_reg.position});

    // no result may be left over when a new sample is taken
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!pend_vld_reg && !e2_vld_reg))
        else $error("pending result while ready for a sample");

    // the divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider result outside a divide state");

    // a bare marker always closes a profile
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("bare marker without end of profile");

    // sample count never passes the profile limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        win.count <= e1d_pkg::CNT_W'(e1d_pkg::MAX_PROFILE_LENGTH))
        else $error("sample count beyond profile limit");

    // the window is cleared once the final sample has been worked through
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && last_reg) |-> (win.count == '0))
        else $error("window not cleared at end of profile");

endmodule

// ===== rtl/core/e1d_win.sv =====
// ----------------------------------------------------------------------------
// e1d_win
// sample and gradient windows with the profile sample counter
// ----------------------------------------------------------------------------
module e1d_win (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  e1d_pkg::win_op_t              op,
    input  logic [e1d_pkg::SAMPLE_W-1:0]  sample,
    output e1d_pkg::win_t                 win
);

    logic [e1d_pkg::SAMPLE_W-1:0]      w0_reg, w0_next;
    logic [e1d_pkg::SAMPLE_W-1:0]      w1_reg, w1_next;
    logic signed [e1d_pkg::GRAD_W-1:0] g0_reg, g0_next;
    logic signed [e1d_pkg::GRAD_W-1:0] g1_reg, g1_next;
    logic signed [e1d_pkg::GRAD_W-1:0] g2_reg, g2_next;
    logic [e1d_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic [e1d_pkg::SAMPLE_W-1:0]      sub_x, sub_y;
    logic                              dbl;
    logic signed [e1d_pkg::SAMPLE_W:0] diff;
    logic signed [e1d_pkg::GRAD_W-1:0] grad;
    logic                              first;

    // one shared subtractor: central difference or doubled end difference
    always_comb begin
        first = (cnt_reg == e1d_pkg::CNT_W'(1));
        dbl   = (op == e1d_pkg::WIN_END) || first;
        sub_x = (op == e1d_pkg::WIN_END) ? w1_reg : sample;
        sub_y = (op == e1d_pkg::WIN_SAMPLE && first) ? w1_reg : w0_reg;
        diff  = $signed({1'b0, sub_x}) - $signed({1'b0, sub_y});
        grad  = dbl ? {diff, 1'b0} : {diff[e1d_pkg::SAMPLE_W], diff};
    end

    always_comb begin
        w0_next  = w0_reg;
        w1_next  = w1_reg;
        g0_next  = g0_reg;
        g1_next  = g1_reg;
        g2_next  = g2_reg;
        cnt_next = cnt_reg;
        unique case (op)
            e1d_pkg::WIN_SAMPLE: begin
                if (cnt_reg != '0) begin
                    g0_next = g1_reg;
                    g1_next = g2_reg;
                    g2_next = grad;
                end
                w0_next  = w1_reg;
                w1_next  = sample;
                cnt_next = cnt_reg + e1d_pkg::CNT_W'(1);
            end
            e1d_pkg::WIN_END: begin
                g0_next = g1_reg;
                g1_next = g2_reg;
                g2_next = grad;
            end
            e1d_pkg::WIN_CLEAR: begin
                w0_next  = '0;
                w1_next  = '0;
                g0_next  = '0;
                g1_next  = '0;
                g2_next  = '0;
                cnt_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_reg  <= '0;
            w1_reg  <= '0;
            g0_reg  <= '0;
            g1_reg  <= '0;
            g2_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            w0_reg  <= w0_next;
            w1_reg  <= w1_next;
            g0_reg  <= g0_next;
            g1_reg  <= g1_next;
            g2_reg  <= g2_next;
            cnt_reg <= cnt_next;
        end
    end

    assign win.g0    = g0_reg;
    assign win.g1    = g1_reg;
    assign win.g2    = g2_reg;
    assign win.count = cnt_reg;

endmodule

// ===== rtl/core/e1d_div.sv =====
// ----------------------------------------------------------------------------
// e1d_div
// parabolic offset: restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module e1d_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [e1d_pkg::AMP_W-1:0]           a,
    input  logic [e1d_pkg::AMP_W-1:0]           b,
    input  logic [e1d_pkg::AMP_W-1:0]           c,
    output logic                                done,
    output logic signed [e1d_pkg::OFF_W-1:0]    offset
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [e1d_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic [e1d_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [e1d_pkg::DEN_W-1:0]         d_reg, d_next;
    logic [e1d_pkg::QBITS-1:0]         q_reg, q_next;
    logic                              sat_reg, sat_next;
    logic                              neg_reg, neg_next;

    logic [e1d_pkg::AMP_W-1:0]         nm;
    logic signed [e1d_pkg::DEN_W-1:0]  dh;
    logic [e1d_pkg::DEN_W-1:0]         dh_neg;
    logic [e1d_pkg::DHALF_W-1:0]       dh_mag;
    logic [e1d_pkg::DEN_W-1:0]         den;
    logic                              ge;
    logic [e1d_pkg::REM_W-1:0]         rr;
    logic [e1d_pkg::OFF_W-1:0]         qmag;

    always_comb begin
        // numerator a-c, half denominator a-2b+c
        nm     = (a >= c) ? (a - c) : (c - a);
        dh     = $signed({2'b00, a}) - $signed({1'b0, b, 1'b0}) + $signed({2'b00, c});
        dh_neg = -dh;
        dh_mag = dh[e1d_pkg::DEN_W-1] ? dh_neg[e1d_pkg::DHALF_W-1:0]
                                      : dh[e1d_pkg::DHALF_W-1:0];
        den    = {dh_mag, 1'b0};

        ge = (rem_reg >= {1'b0, d_reg});
        rr = ge ? (rem_reg - {1'b0, d_reg}) : rem_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;

        if (start) begin
            d_next   = den;
            neg_next = (a < c) ^ dh[e1d_pkg::DEN_W-1];
            q_next   = '0;
            sat_next = 1'b0;
            rem_next = e1d_pkg::REM_W'(nm);
            if (den == '0) begin
                done_next = 1'b1;
            end else if (e1d_pkg::REM_W'(nm) >= {den, 1'b0}) begin
                // quotient would not fit, clamp
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                cnt_next  = e1d_pkg::QCNT_W'(e1d_pkg::QBITS);
            end
        end else if (busy_reg) begin
            q_next   = {q_reg[e1d_pkg::QBITS-2:0], ge};
            rem_next = {rr[e1d_pkg::REM_W-2:0], 1'b0};
            cnt_next = cnt_reg - e1d_pkg::QCNT_W'(1);
            if (cnt_reg == e1d_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        qmag   = (sat_reg || (q_reg > e1d_pkg::OFF_LIMIT)) ? e1d_pkg::OFF_LIMIT : q_reg;
        offset = neg_reg ? -$signed(qmag) : $signed(qmag);
    end

    assign done = done_reg;

endmodule
